// File: design/assert_macros.svh
// Assertion macros shared by the RC channel frame decoder RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Expression must never be true out of reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: design/rcfd_pkg.sv
// Shared types and constants for the RC channel frame decoder.
// No dependencies; imported by the front, queue, back and top.
`default_nettype none

package rcfd_pkg;

	// Frame layout
	localparam logic [7:0]  START_BYTE    = 8'h20;
	localparam logic [7:0]  SECOND_BYTE   = 8'h40;
	localparam logic [15:0] SUM_TARGET    = 16'hFFFF;
	localparam int          FRAME_BYTES   = 32;
	localparam int          SUMMED_BYTES  = 30;
	localparam int          FIRST_CH_BYTE = 2;
	localparam int          CHANNELS      = 14;

	localparam int BYTE_AW     = $clog2(FRAME_BYTES);
	localparam int STORE_DEPTH = 2 * FRAME_BYTES;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int CH_W        = 4;

	// Result status codes
	typedef enum logic [1:0] {
		ST_CHANNEL  = 2'd0,
		ST_HDR_ERR  = 2'd1,
		ST_CSUM_ERR = 2'd2
	} status_t;

	// One closed frame waiting for the back end
	typedef struct packed {
		logic    bank;
		status_t status;
	} desc_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} push_t;

	// Frame store write port
	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          data;
	} ram_wr_t;

endpackage

`default_nettype wire

// File: design/rcfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module rcfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: design/rcfd_front.sv
// Front end: hunts for the start byte, stores frame bytes, keeps the running
// sum and judges header and checksum at frame close. Uses rcfd_pkg.
`default_nettype none

module rcfd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       in_byte,
	input  wire logic             fifo_full,
	output rcfd_pkg::push_t       push,
	output rcfd_pkg::ram_wr_t     wr
);

	import rcfd_pkg::*;

	logic               in_frame_q;
	logic [BYTE_AW-1:0] cnt_q;
	logic [15:0]        sum_q;
	logic [7:0]         byte1_q;
	logic [7:0]         byte30_q;
	logic               bank_q;
	logic               beat;
	logic               closing;
	logic [16:0]        check_sum;
	status_t            close_status;

	// A new frame may only open when a store bank is free
	assign in_ready = in_frame_q | ~fifo_full;
	assign beat     = in_valid & in_ready;
	assign closing  = beat & in_frame_q & (cnt_q == BYTE_AW'(FRAME_BYTES - 1));

	// Sum plus little-endian checksum, no wrap
	assign check_sum = {1'b0, sum_q} + {1'b0, in_byte, byte30_q};

	always_comb begin
		if (byte1_q != SECOND_BYTE) begin
			close_status = ST_HDR_ERR;
		end else if (check_sum != {1'b0, SUM_TARGET}) begin
			close_status = ST_CSUM_ERR;
		end else begin
			close_status = ST_CHANNEL;
		end
	end

	// Store write: every byte of an open frame, plus the start byte
	always_comb begin
		wr.en   = beat & (in_frame_q | (in_byte == START_BYTE));
		wr.addr = {bank_q, in_frame_q ? cnt_q : BYTE_AW'(0)};
		wr.data = in_byte;
	end

	always_comb begin
		push.valid       = closing;
		push.desc.bank   = bank_q;
		push.desc.status = close_status;
	end

	// Frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			sum_q      <= '0;
			bank_q     <= 1'b0;
		end else if (beat) begin
			if (!in_frame_q) begin
				if (in_byte == START_BYTE) begin
					in_frame_q <= 1'b1;
					cnt_q      <= BYTE_AW'(1);
					sum_q      <= {8'h00, in_byte};
				end
			end else if (closing) begin
				in_frame_q <= 1'b0;
				cnt_q      <= '0;
				sum_q      <= '0;
				bank_q     <= ~bank_q;
			end else begin
				cnt_q <= cnt_q + BYTE_AW'(1);
				if (cnt_q < BYTE_AW'(SUMMED_BYTES)) begin
					sum_q <= sum_q + {8'h00, in_byte};
				end
			end
		end
	end

	// Header and checksum-low bytes kept for the close check
	always_ff @(posedge clk) begin
		if (beat && in_frame_q) begin
			if (cnt_q == BYTE_AW'(1)) begin
				byte1_q <= in_byte;
			end
			if (cnt_q == BYTE_AW'(SUMMED_BYTES)) begin
				byte30_q <= in_byte;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/rcfd_desc_fifo.sv
// Two-entry queue of closed-frame descriptors between front and back end.
// Uses rcfd_pkg.
`default_nettype none

module rcfd_desc_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rcfd_pkg::push_t push,
	input  wire logic           pop,
	output rcfd_pkg::desc_t     head,
	output logic                empty,
	output logic                full
);

	import rcfd_pkg::*;

	desc_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign do_push = push.valid & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.desc;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/rcfd_back.sv
// Back end: reads a closed frame out of the store and emits channel results,
// or one error result. Uses rcfd_pkg.
`default_nettype none

module rcfd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rcfd_pkg::desc_t               head,
	input  wire logic                          empty,
	output logic                               pop,
	output logic [rcfd_pkg::STORE_AW-1:0]      rd_addr,
	input  wire logic [7:0]                    rd_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [23:0]                        out_data,
	output logic                               out_last
);

	import rcfd_pkg::*;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_LO   = 5'b00010,
		B_HI   = 5'b00100,
		B_CAP  = 5'b01000,
		B_OUT  = 5'b10000
	} back_state_t;

	back_state_t     state_q;
	logic [CH_W-1:0] ch_q;
	logic [7:0]      lo_q;
	status_t         st_q;
	logic [CH_W-1:0] idx_q;
	logic [15:0]     val_q;
	logic            last_q;
	logic [BYTE_AW-1:0] lo_pos;
	logic            ch_last;

	assign lo_pos  = {ch_q, 1'b0} + BYTE_AW'(FIRST_CH_BYTE);
	assign ch_last = (ch_q == CH_W'(CHANNELS - 1));

	// Low byte address in B_LO, high byte address otherwise
	assign rd_addr = {head.bank, (state_q == B_LO) ? lo_pos : lo_pos + BYTE_AW'(1)};

	assign out_valid = (state_q == B_OUT);
	assign out_data  = {2'b00, val_q, idx_q, st_q};
	assign out_last  = last_q;
	assign pop       = out_valid & out_ready & last_q;

	// Readout sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ch_q    <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						ch_q    <= '0;
						state_q <= (head.status == ST_CHANNEL) ? B_LO : B_OUT;
					end
				end
				B_LO:  state_q <= B_HI;
				B_HI:  state_q <= B_CAP;
				B_CAP: state_q <= B_OUT;
				B_OUT: begin
					if (out_ready) begin
						if (last_q) begin
							state_q <= B_IDLE;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= B_LO;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !empty) begin
			st_q   <= head.status;
			idx_q  <= '0;
			val_q  <= '0;
			last_q <= 1'b1;
		end
		if (state_q == B_HI) begin
			lo_q <= rd_data;
		end
		if (state_q == B_CAP) begin
			st_q   <= ST_CHANNEL;
			idx_q  <= ch_q;
			val_q  <= {rd_data, lo_q};
			last_q <= ch_last;
		end
	end

endmodule

`default_nettype wire

// File: design/rc_channel_frame_decoder_core.sv
// Top level of the RC channel frame decoder: front end, descriptor queue,
// two-bank frame store and back end. Uses rcfd_pkg and assert_macros.svh.
//
//   channel  | dir | tdata bits (low first)                          | tlast
//   s_axis   | in  | [7:0] rx_byte                                   | -
//   m_axis   | out | [1:0] status, [5:2] channel_index,              | last
//            |     | [21:6] channel_value, [23:22] zero              |
//
// Input bytes are taken one per cycle while s_axis_tready is high; the front
// end does a 16-bit add and a store write per beat. A good frame drains as:
// pick up the descriptor, then per channel two store reads, capture, output
// beat; an error frame: pick up the descriptor, one output beat. The store
// has two frame banks, so input stalls only between frames, while two closed
// frames are still waiting. Reset clears all control state; no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module rc_channel_frame_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [1:0] status, [5:2] channel_index,
	                                         // [21:6] channel_value, [23:22] zero
	output logic             m_axis_tlast    // last
);

	import rcfd_pkg::*;

	push_t               push;
	ram_wr_t             wr;
	desc_t               head;
	logic                fifo_empty;
	logic                fifo_full;
	logic                pop;
	logic [STORE_AW-1:0] rd_addr;
	logic [7:0]          rd_data;
	logic                out_err;

	rcfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.fifo_full (fifo_full),
		.push      (push),
		.wr        (wr)
	);

	rcfd_desc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (fifo_empty),
		.full   (fifo_full)
	);

	rcfd_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rcfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (fifo_empty),
		.pop       (pop),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	assign out_err = m_axis_tvalid && (m_axis_tdata[1:0] != ST_CHANNEL);

	// A frame never closes into a full queue
	`ASSERT_NEVER(a_no_push_full, push.valid && fifo_full, "frame closed with queue full")

	// Results only while a frame descriptor is held
	`ASSERT_IMPLIES(a_out_has_desc, m_axis_tvalid, !fifo_empty, "result without descriptor")

	// Error results stand alone
	`ASSERT_IMPLIES(a_err_is_last, out_err, m_axis_tlast, "error result not last")

endmodule

`default_nettype wire
